FILE: hdl/tks_pkg.sv
// Package for the top-k token sampler: field widths, default sizes,
// payload structs of both channels and the queue status struct.
// No dependencies.
package tks_pkg;

  localparam int unsigned PROB_W         = 16;
  localparam int unsigned DRAW_W         = 16;
  localparam int unsigned TOKEN_W        = 17;
  localparam int unsigned RANK_W         = 3;
  localparam int unsigned TOP_K_DEF      = 6;
  localparam int unsigned INDEX_BITS_DEF = 17;

  typedef struct packed {
    logic [PROB_W-1:0] prob_value;
    logic              is_last;
    logic [DRAW_W-1:0] random_draw;
  } tks_in_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] token_index;
    logic [RANK_W-1:0]  chosen_rank;
    logic               short_list;
  } tks_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tks_q_stat_t;

endpackage

FILE: hdl/tks_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Depends on nothing; payload types come from tks_pkg at the point of use.
interface tks_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/tks_front.sv
// Front part: accepts probability items and keeps the ranked top-k list.
// On the last item of a row, pushes the finished list into the queue.
// Depends on tks_pkg and tks_stream_if.
module tks_front #(
  parameter int unsigned TOP_K      = tks_pkg::TOP_K_DEF,
  parameter int unsigned INDEX_BITS = tks_pkg::INDEX_BITS_DEF,
  localparam int unsigned HELD_W    = $clog2(TOP_K + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tks_stream_if.sink                in_i,
  input  tks_pkg::tks_q_stat_t      q_stat_i,
  output logic                      push_o,
  output logic [tks_pkg::PROB_W-1:0] snap_vals_o [TOP_K],
  output logic [INDEX_BITS-1:0]     snap_idxs_o [TOP_K],
  output logic [HELD_W-1:0]         snap_held_o,
  output logic [tks_pkg::DRAW_W-1:0] snap_draw_o
);
  import tks_pkg::*;

  logic [PROB_W-1:0]     vals_q [TOP_K];
  logic [PROB_W-1:0]     vals_d [TOP_K];
  logic [INDEX_BITS-1:0] idxs_q [TOP_K];
  logic [INDEX_BITS-1:0] idxs_d [TOP_K];
  logic [HELD_W-1:0]     held_q;
  logic [HELD_W-1:0]     held_d;
  logic [INDEX_BITS-1:0] cnt_q;
  logic [TOP_K-1:0]      ins;
  logic                  accept;

  assign in_i.ready = ~q_stat_i.full;
  assign accept     = in_i.valid & in_i.ready;

  always_comb begin
    for (int j = 0; j < TOP_K; j++) begin
      ins[j] = (HELD_W'(j) >= held_q) ||
               (in_i.data.prob_value > vals_q[j]) ||
               ((in_i.data.prob_value == vals_q[j]) && (cnt_q > idxs_q[j]));
    end
    vals_d[0] = ins[0] ? in_i.data.prob_value : vals_q[0];
    idxs_d[0] = ins[0] ? cnt_q : idxs_q[0];
    for (int j = 1; j < TOP_K; j++) begin
      if (ins[j] && !ins[j-1]) begin
        vals_d[j] = in_i.data.prob_value;
        idxs_d[j] = cnt_q;
      end else if (ins[j]) begin
        vals_d[j] = vals_q[j-1];
        idxs_d[j] = idxs_q[j-1];
      end else begin
        vals_d[j] = vals_q[j];
        idxs_d[j] = idxs_q[j];
      end
    end
    held_d = (held_q < HELD_W'(TOP_K)) ? held_q + HELD_W'(1) : held_q;
  end

  assign push_o      = accept & in_i.data.is_last;
  assign snap_vals_o = vals_d;
  assign snap_idxs_o = idxs_d;
  assign snap_held_o = held_d;
  assign snap_draw_o = in_i.data.random_draw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      if (in_i.data.is_last) begin
        held_q <= '0;
        cnt_q  <= '0;
      end else begin
        held_q <= held_d;
        if (cnt_q != '1) begin
          cnt_q <= cnt_q + INDEX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vals_q <= vals_d;
      idxs_q <= idxs_d;
    end
  end

endmodule

FILE: hdl/tks_queue.sv
// Two-entry queue of finished top-k lists between front and back.
// Depends on tks_pkg.
module tks_queue #(
  parameter int unsigned TOP_K      = tks_pkg::TOP_K_DEF,
  parameter int unsigned INDEX_BITS = tks_pkg::INDEX_BITS_DEF,
  localparam int unsigned HELD_W    = $clog2(TOP_K + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [tks_pkg::PROB_W-1:0] wr_vals_i [TOP_K],
  input  logic [INDEX_BITS-1:0]      wr_idxs_i [TOP_K],
  input  logic [HELD_W-1:0]          wr_held_i,
  input  logic [tks_pkg::DRAW_W-1:0] wr_draw_i,
  input  logic                       pop_i,
  output tks_pkg::tks_q_stat_t       stat_o,
  output logic [tks_pkg::PROB_W-1:0] rd_vals_o [TOP_K],
  output logic [INDEX_BITS-1:0]      rd_idxs_o [TOP_K],
  output logic [HELD_W-1:0]          rd_held_o,
  output logic [tks_pkg::DRAW_W-1:0] rd_draw_o
);
  import tks_pkg::*;

  logic [PROB_W-1:0]     vals_q [2][TOP_K];
  logic [INDEX_BITS-1:0] idxs_q [2][TOP_K];
  logic [HELD_W-1:0]     held_q [2];
  logic [DRAW_W-1:0]     draw_q [2];
  logic                  wptr_q;
  logic                  rptr_q;
  logic [1:0]            count_q;
  logic                  do_push;
  logic                  do_pop;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;

  assign rd_vals_o = vals_q[rptr_q];
  assign rd_idxs_o = idxs_q[rptr_q];
  assign rd_held_o = held_q[rptr_q];
  assign rd_draw_o = draw_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      vals_q[wptr_q] <= wr_vals_i;
      idxs_q[wptr_q] <= wr_idxs_i;
      held_q[wptr_q] <= wr_held_i;
      draw_q[wptr_q] <= wr_draw_i;
    end
  end

endmodule

FILE: hdl/tks_back.sv
// Back part: takes a finished list from the queue, sums it, scales the
// draw and walks the running sum to pick a rank; holds the result.
// Depends on tks_pkg and tks_stream_if.
module tks_back #(
  parameter int unsigned TOP_K      = tks_pkg::TOP_K_DEF,
  parameter int unsigned INDEX_BITS = tks_pkg::INDEX_BITS_DEF,
  localparam int unsigned HELD_W    = $clog2(TOP_K + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tks_pkg::tks_q_stat_t       q_stat_i,
  output logic                       pop_o,
  input  logic [tks_pkg::PROB_W-1:0] rd_vals_i [TOP_K],
  input  logic [INDEX_BITS-1:0]      rd_idxs_i [TOP_K],
  input  logic [HELD_W-1:0]          rd_held_i,
  input  logic [tks_pkg::DRAW_W-1:0] rd_draw_i,
  tks_stream_if.source               out_o
);
  import tks_pkg::*;

  localparam int unsigned RK_W  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int unsigned SUM_W = PROB_W + HELD_W;
  localparam int unsigned PRD_W = DRAW_W + SUM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_WALK,
    S_OUT
  } state_e;

  state_e                state_q;
  logic [PROB_W-1:0]     vals_q [TOP_K];
  logic [INDEX_BITS-1:0] idxs_q [TOP_K];
  logic [HELD_W-1:0]     held_q;
  logic [DRAW_W-1:0]     draw_q;
  logic [RK_W-1:0]       i_q;
  logic [SUM_W-1:0]      sum_q;
  logic [SUM_W-1:0]      run_d;
  logic [SUM_W-1:0]      target_q;
  logic [PRD_W-1:0]      prod;
  logic                  at_end;
  logic [INDEX_BITS-1:0] token_q;
  logic [RK_W-1:0]       rank_q;
  logic                  short_q;
  logic [INDEX_BITS+TOKEN_W-1:0] token_ext;
  logic [RK_W+RANK_W-1:0]        rank_ext;

  assign pop_o  = (state_q == S_IDLE) & ~q_stat_i.empty;
  assign at_end = (HELD_W'(i_q) == held_q - HELD_W'(1));
  assign prod   = PRD_W'(draw_q) * PRD_W'(sum_q);
  assign run_d  = sum_q + SUM_W'(vals_q[i_q]);

  assign token_ext = {{TOKEN_W{1'b0}}, token_q};
  assign rank_ext  = {{RANK_W{1'b0}}, rank_q};

  assign out_o.valid            = (state_q == S_OUT);
  assign out_o.data.token_index = token_ext[TOKEN_W-1:0];
  assign out_o.data.chosen_rank = rank_ext[RANK_W-1:0];
  assign out_o.data.short_list  = short_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      vals_q   <= '{default: '0};
      idxs_q   <= '{default: '0};
      held_q   <= '0;
      draw_q   <= '0;
      sum_q    <= '0;
      target_q <= '0;
      token_q  <= '0;
      rank_q   <= '0;
      short_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          vals_q  <= rd_vals_i;
          idxs_q  <= rd_idxs_i;
          held_q  <= rd_held_i;
          draw_q  <= rd_draw_i;
          sum_q   <= '0;
          short_q <= (rd_held_i < HELD_W'(TOP_K));
          if (!q_stat_i.empty) begin
            i_q     <= '0;
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          sum_q <= run_d;
          if (at_end) begin
            state_q <= S_MUL;
          end else begin
            i_q <= i_q + RK_W'(1);
          end
        end
        S_MUL: begin
          target_q <= prod[DRAW_W +: SUM_W];
          sum_q    <= '0;
          i_q      <= '0;
          state_q  <= S_WALK;
        end
        S_WALK: begin
          sum_q <= run_d;
          if (run_d > target_q) begin
            rank_q  <= i_q;
            token_q <= idxs_q[i_q];
            state_q <= S_OUT;
          end else if (at_end) begin
            rank_q  <= '0;
            token_q <= idxs_q[0];
            state_q <= S_OUT;
          end else begin
            i_q <= i_q + RK_W'(1);
          end
        end
        S_OUT: begin
          if (out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/top_k_token_sampler_core.sv
// Top level of the top-k token sampler: front list keeper, snapshot queue
// and sampling back end. Depends on tks_pkg, tks_stream_if, tks_front,
// tks_queue and tks_back.
//
//  channel | dir | payload                                  | accepted when
//  in_i    | in  | prob_value, is_last, random_draw         | valid & ready
//  out_o   | out | token_index, chosen_rank, short_list     | valid & ready
//
// One probability item is accepted every cycle while the queue is not full;
// the top-k list updates in that cycle. A row's result appears once the
// back end has summed the held ranks, scaled the draw and walked up to the pick.
// Reset is asynchronous and active low and clears all control state.
// Input stalls only when two finished rows wait in the queue.
module top_k_token_sampler_core #(
  parameter int unsigned TOP_K      = tks_pkg::TOP_K_DEF,
  parameter int unsigned INDEX_BITS = tks_pkg::INDEX_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tks_stream_if.sink   in_i,
  tks_stream_if.source out_o
);
  import tks_pkg::*;

  localparam int unsigned HELD_W = $clog2(TOP_K + 1);

  tks_q_stat_t           q_stat;
  logic                  push;
  logic                  pop;
  logic [PROB_W-1:0]     snap_vals [TOP_K];
  logic [INDEX_BITS-1:0] snap_idxs [TOP_K];
  logic [HELD_W-1:0]     snap_held;
  logic [DRAW_W-1:0]     snap_draw;
  logic [PROB_W-1:0]     head_vals [TOP_K];
  logic [INDEX_BITS-1:0] head_idxs [TOP_K];
  logic [HELD_W-1:0]     head_held;
  logic [DRAW_W-1:0]     head_draw;

  tks_front #(
    .TOP_K      (TOP_K),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .snap_vals_o (snap_vals),
    .snap_idxs_o (snap_idxs),
    .snap_held_o (snap_held),
    .snap_draw_o (snap_draw)
  );

  tks_queue #(
    .TOP_K      (TOP_K),
    .INDEX_BITS (INDEX_BITS)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_vals_i (snap_vals),
    .wr_idxs_i (snap_idxs),
    .wr_held_i (snap_held),
    .wr_draw_i (snap_draw),
    .pop_i     (pop),
    .stat_o    (q_stat),
    .rd_vals_o (head_vals),
    .rd_idxs_o (head_idxs),
    .rd_held_o (head_held),
    .rd_draw_o (head_draw)
  );

  tks_back #(
    .TOP_K      (TOP_K),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .pop_o     (pop),
    .rd_vals_i (head_vals),
    .rd_idxs_i (head_idxs),
    .rd_held_i (head_held),
    .rd_draw_i (head_draw),
    .out_o     (out_o)
  );

endmodule
